### src/rotb_pkg.sv
// package: transaction types, request kinds and controller types for the translation buffer
`default_nettype none

package rotb_pkg;

   localparam int PAGE_W = 52;

   localparam logic [1:0] KIND_FILL   = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [PAGE_W-1:0] virt_page;
      logic [PAGE_W-1:0] phys_page;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [PAGE_W-1:0] phys_out;
      logic              evicted;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

### src/rotb_ctrl.sv
// controller: sequences search, update and result hand-off
`default_nettype none

module rotb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rotb_pkg::ctrl_cmd_type     cmd
);

   rotb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rotb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         rotb_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = rotb_pkg::ST_UPDATE;
            end
         end
         rotb_pkg::ST_UPDATE: begin
            // output register must be free or emptying this cycle
            cmd.commit = !rsp_valid_ff || rsp_ready;
            if (cmd.commit) begin
               state_in = rotb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rotb_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### src/rotb_dpath.sv
// datapath: slot array, associative search, recency shifts and result register
`default_nettype none

module rotb_dpath #(
   parameter int BUFFER_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rotb_pkg::ctrl_cmd_type cmd,
   input  wire rotb_pkg::req_type     req_data,
   output rotb_pkg::rsp_type          rsp_data
);

   localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);

   logic [rotb_pkg::PAGE_W-1:0] virt_slots_ff [BUFFER_DEPTH];
   logic [rotb_pkg::PAGE_W-1:0] phys_slots_ff [BUFFER_DEPTH];
   logic [rotb_pkg::PAGE_W-1:0] virt_slots_in [BUFFER_DEPTH];
   logic [rotb_pkg::PAGE_W-1:0] phys_slots_in [BUFFER_DEPTH];
   logic [OCC_W-1:0]            occ_ff, occ_in;

   rotb_pkg::req_type           req_ff;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   rotb_pkg::rsp_type           rsp_ff, rsp_in;

   logic [BUFFER_DEPTH-1:0]     match;
   logic                        full;
   logic [rotb_pkg::PAGE_W-1:0] hit_virt;
   logic [rotb_pkg::PAGE_W-1:0] hit_phys;

   // parallel compare of the incoming page against every live slot
   always_comb begin
      match  = '0;
      pos_in = '0;
      for (int k = 0; k < BUFFER_DEPTH; k++) begin
         match[k] = (OCC_W'(k) < occ_ff) && (virt_slots_ff[k] == req_data.virt_page);
      end
      for (int k = BUFFER_DEPTH - 1; k >= 0; k--) begin
         if (match[k]) begin
            pos_in = IDX_W'(k);
         end
      end
      hit_in = |match;
   end

   assign full     = (occ_ff == OCC_W'(BUFFER_DEPTH));
   assign hit_virt = virt_slots_ff[pos_ff];
   assign hit_phys = phys_slots_ff[pos_ff];

   always_comb begin
      virt_slots_in = virt_slots_ff;
      phys_slots_in = phys_slots_ff;
      occ_in        = occ_ff;
      rsp_in        = '0;
      case (req_ff.kind)
         rotb_pkg::KIND_FILL: begin
            if (hit_ff) begin
               // move hit entry to the front, keep its translation
               for (int k = 1; k < BUFFER_DEPTH; k++) begin
                  if (IDX_W'(k) <= pos_ff) begin
                     virt_slots_in[k] = virt_slots_ff[k-1];
                     phys_slots_in[k] = phys_slots_ff[k-1];
                  end
               end
               virt_slots_in[0] = hit_virt;
               phys_slots_in[0] = hit_phys;
               rsp_in.found     = 1'b1;
            end else begin
               for (int k = 1; k < BUFFER_DEPTH; k++) begin
                  virt_slots_in[k] = virt_slots_ff[k-1];
                  phys_slots_in[k] = phys_slots_ff[k-1];
               end
               virt_slots_in[0] = req_ff.virt_page;
               phys_slots_in[0] = req_ff.phys_page;
               rsp_in.evicted   = full;
               if (!full) begin
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
         end
         rotb_pkg::KIND_LOOKUP: begin
            rsp_in.found = hit_ff;
         end
         rotb_pkg::KIND_POP: begin
            if (hit_ff) begin
               // close the gap behind the removed entry
               for (int k = 0; k < BUFFER_DEPTH - 1; k++) begin
                  if (IDX_W'(k) >= pos_ff) begin
                     virt_slots_in[k] = virt_slots_ff[k+1];
                     phys_slots_in[k] = phys_slots_ff[k+1];
                  end
               end
               occ_in          = occ_ff - OCC_W'(1);
               rsp_in.found    = 1'b1;
               rsp_in.phys_out = hit_phys;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.commit) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         hit_ff <= hit_in;
         pos_ff <= pos_in;
      end
      if (cmd.commit) begin
         virt_slots_ff <= virt_slots_in;
         phys_slots_ff <= phys_slots_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### src/recency_ordered_translation_buffer.sv
// top level: recency-ordered, fully associative buffer of page translations
// usage
//   req_* channel carries one transaction: kind (fill, lookup, pop), virtual
//   page and physical page; rsp_* channel returns found, phys_out, evicted
//   exactly one response transaction per request, in request order
// timing
//   the request is searched against all live slots in the cycle it is
//   accepted; in the update state the slot array is reordered and the
//   response is registered together, once the output register is free
//   a new request is accepted only once the previous update has committed,
//   due to the search-then-update sequence on the single shared slot array
// reset
//   synchronous reset empties the buffer (occupancy zero) and drops any
//   response in flight; slot contents are not cleared
// back-pressure
//   a finished response waits in the output register while rsp_ready is low;
//   meanwhile one further request is accepted and searched, and its update
//   is held back until the output register is taken
`default_nettype none

module recency_ordered_translation_buffer #(
   parameter int BUFFER_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rotb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rotb_pkg::rsp_type      rsp_data
);

   // capture/commit strobes from the sequencer to the slot datapath
   rotb_pkg::ctrl_cmd_type cmd;

   rotb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // slot array with the associative search and the recency shifts
   rotb_dpath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
